// ----- hw/rtl/bounded_array_list_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bounded array list
// Clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ASSERT_SVH

// Condition holds at every clock edge.
`define BAL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BAL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bal_pkg.sv -----
// ----------------------------------------------------------------------------
// bal_pkg
// Shared constants and codes for the bounded array list.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int BAL_DEPTH        = 16;
  localparam int BAL_PAYLOAD_BITS = 64;
  localparam int ID_W             = 32;
  localparam int OP_W             = 3;
  localparam int POS_W            = 5;
  localparam int STATUS_W         = 3;
  localparam int CNT_OUT_W        = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_END   = 3'd3,
    OP_READ_POS  = 3'd4,
    OP_FIND_ID   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DOWN,
    S_SCAN,
    S_READ,
    S_PUT,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/bal_ram.sv -----
// ----------------------------------------------------------------------------
// bal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/bounded_array_list.sv -----
// ----------------------------------------------------------------------------
// bounded_array_list
// Fixed-capacity ordered list of (id, payload) records held in one RAM,
// with front/end insert and remove, read by position and find by id.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------------------
//   in_     | input     | in_valid / in_stall   | operation, id, payload, position, key
//   out_    | output    | out_valid / out_stall | status, found id, found payload, count
//
// End insert/remove, front insert into an empty list, rejects and unused codes go
// straight to the output register; read, find and front remove sweep the RAM, and
// front insert sweeps it and then writes the new record to slot 0; each sweep reads
// one entry a cycle through the one RAM read port.
// Reset (synchronous, rst_n low) clears control and out_valid, not the RAM or data; in_stall is high while a
// word is in work, and a waiting result holds only the finish of the next word.
// ----------------------------------------------------------------------------
`include "bounded_array_list_assert.svh"

module bounded_array_list #(
  parameter int DEPTH        = bal_pkg::BAL_DEPTH,
  parameter int PAYLOAD_BITS = bal_pkg::BAL_PAYLOAD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bal_pkg::OP_W-1:0]            in_operation,
  input  logic signed [bal_pkg::ID_W-1:0]     in_entry_id,
  input  logic [PAYLOAD_BITS-1:0]             in_entry_payload,
  input  logic [bal_pkg::POS_W-1:0]           in_position,
  input  logic signed [bal_pkg::ID_W-1:0]     in_key_id,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bal_pkg::STATUS_W-1:0]        out_status,
  output logic signed [bal_pkg::ID_W-1:0]     out_found_id,
  output logic [PAYLOAD_BITS-1:0]             out_found_payload,
  output logic [bal_pkg::CNT_OUT_W-1:0]       out_count
);

  import bal_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int REC_W = ID_W + PAYLOAD_BITS;

  // Sequencer and sweep state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;     // records held
  logic [AW-1:0]     ptr_r, ptr_nxt;         // next RAM address to read
  logic [CW-1:0]     left_r, left_nxt;       // reads still to issue
  logic              rvalid_r, rvalid_nxt;   // RAM read data valid this cycle
  logic [AW-1:0]     src_r, src_nxt;         // address of that read data

  // Word under work
  logic [REC_W-1:0]  new_rec_r, new_rec_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [REC_W-1:0]  res_rec_r, res_rec_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [REC_W-1:0]      out_rec_r, out_rec_nxt;
  logic [CNT_OUT_W-1:0]  out_count_r, out_count_nxt;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [REC_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [REC_W-1:0]  ram_rdata;

  logic in_accept;
  logic out_free;
  logic is_full;
  logic is_empty;
  logic pos_ok;
  logic sweep_done;
  logic issue;
  logic sweeping;

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign is_full    = (32'(count_r) >= DEPTH);
  assign is_empty   = (count_r == '0);
  // Position is 1-based; zero or anything past the count is rejected
  assign pos_ok     = (in_position != '0) && (32'(in_position) <= 32'(count_r));
  assign sweeping   = (state_r == S_UP) || (state_r == S_DOWN) ||
                      (state_r == S_SCAN) || (state_r == S_READ);
  assign issue      = sweeping && (left_r != '0);
  // Sweep ends once every read is issued and the last data has been used
  assign sweep_done = (left_r == '0) && !rvalid_r;

  bal_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      S_IDLE: begin
        if (in_accept) begin
          case (op_t'(in_operation))
            OP_INS_FRONT: state_nxt = (is_full || is_empty) ? S_DONE : S_UP;
            OP_REM_FRONT: state_nxt = is_empty ? S_DONE : S_DOWN;
            OP_READ_POS:  state_nxt = (!is_empty && pos_ok) ? S_READ : S_DONE;
            OP_FIND_ID:   state_nxt = is_empty ? S_DONE : S_SCAN;
            default:      state_nxt = S_DONE;
          endcase
        end
      end
      S_UP: begin
        if (sweep_done) state_nxt = S_PUT;
      end
      S_DOWN, S_SCAN, S_READ: begin
        if (sweep_done) state_nxt = S_DONE;
      end
      S_PUT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and RAM control
  // --------------------------------------------------------------------------
  always_comb begin
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    left_nxt       = left_r;
    rvalid_nxt     = issue;
    src_nxt        = ptr_r;
    new_rec_nxt    = new_rec_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = src_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = ptr_r;

    // Advance the read pointer one entry per cycle while reads remain
    if (issue) begin
      left_nxt = left_r - 1'b1;
      ptr_nxt  = (state_r == S_UP) ? ptr_r - 1'b1 : ptr_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          new_rec_nxt    = {in_entry_id, in_entry_payload};
          key_nxt        = in_key_id;
          res_status_nxt = ST_OK;
          res_rec_nxt    = '0;
          left_nxt       = '0;
          case (op_t'(in_operation))
            OP_INS_FRONT: begin
              if (is_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
                if (is_empty) begin
                  // Nothing to move: drop the record straight into slot 0
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = {in_entry_id, in_entry_payload};
                end else begin
                  ptr_nxt  = AW'(count_r - 1'b1);
                  left_nxt = count_r;
                end
              end
            end
            OP_INS_END: begin
              if (is_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
                ram_we    = 1'b1;
                ram_waddr = AW'(count_r);
                ram_wdata = {in_entry_id, in_entry_payload};
              end
            end
            OP_REM_FRONT: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                ptr_nxt   = AW'(1);
                left_nxt  = count_r - 1'b1;
              end
            end
            OP_REM_END: begin
              if (is_empty) res_status_nxt = ST_EMPTY;
              else count_nxt = count_r - 1'b1;
            end
            OP_READ_POS: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else if (!pos_ok) begin
                res_status_nxt = ST_BAD_POS;
              end else begin
                ptr_nxt  = AW'(in_position - 1'b1);
                left_nxt = CW'(1);
              end
            end
            OP_FIND_ID: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                res_status_nxt = ST_NOT_FOUND;
                ptr_nxt        = '0;
                left_nxt       = count_r;
              end
            end
            default: ;
          endcase
        end
      end
      S_UP: begin
        // Move each entry one slot up, top first
        if (rvalid_r) begin
          ram_we    = 1'b1;
          ram_waddr = src_r + 1'b1;
        end
      end
      S_DOWN: begin
        // Move each entry one slot down, bottom first
        if (rvalid_r) begin
          ram_we    = 1'b1;
          ram_waddr = src_r - 1'b1;
        end
      end
      S_SCAN: begin
        // Later matches overwrite earlier ones: keep the last hit
        if (rvalid_r && (ram_rdata[REC_W-1 -: ID_W] == key_r)) begin
          res_rec_nxt    = ram_rdata;
          res_status_nxt = ST_OK;
        end
      end
      S_READ: begin
        if (rvalid_r) res_rec_nxt = ram_rdata;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_rec_r;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rec_nxt    = res_rec_r;
          out_count_nxt  = CNT_OUT_W'(count_r);
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    src_r        <= src_nxt;
    new_rec_r    <= new_rec_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_id      = out_rec_r[REC_W-1 -: ID_W];
  assign out_found_payload = out_rec_r[PAYLOAD_BITS-1:0];
  assign out_count         = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BAL_ASSERT_ALWAYS(a_count_bound, 32'(count_r) <= DEPTH, "record count above capacity")
  `BAL_ASSERT_SAME(a_write_in_range, ram_we, 32'(ram_waddr) < DEPTH, "RAM write past capacity")
  `BAL_ASSERT_NEXT(a_done_loads, (state_r == S_DONE) && out_free, out_valid_r, "result not loaded")

endmodule
